### rtl/r2d_pkg.sv
`timescale 1ns / 1ps

package r2d_pkg;

  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned ALPHA_W   = 64;
  localparam int unsigned NUM_SYMS  = 16;
  localparam int unsigned MAX_RADIX = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [RADIX_W-1:0] RADIX_RESET     = 5'd10;
  localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h0000_0000_0000_3938;

  localparam logic [SYM_W-1:0] PRINT_MIN  = 8'd32;
  localparam logic [SYM_W-1:0] PRINT_MAX  = 8'd126;
  localparam logic [SYM_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [SYM_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [SYM_W-1:0] NULL_SYM   = 8'h00;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT,
    ST_INVALID
  } state_t;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_stat_t;

  typedef struct packed {
    logic               done;
    logic               last;
    logic [DIGIT_W-1:0] digit;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  function automatic logic [SYM_W-1:0] symbol_at(input logic [2*ALPHA_W-1:0] alpha,
                                                 input logic [DIGIT_W-1:0] idx);
    return alpha[{idx, 3'b000} +: SYM_W];
  endfunction

endpackage

### rtl/signed_integer_to_radix_digits_core.sv
`timescale 1ns / 1ps
// sequence: the alphabet check examines each symbol in use in turn, stopping early on a
//   fault; the bit-serial divider produces the digits lsb first; a minus sign is sent
//   for a negative value; each digit character then takes a stack read and an output load
//   (output stalls hold it)
// throughput: one value at a time, set by the one-bit-per-cycle divider
// reset: config registers return to radix 10 and alphabet "0123456789", control idle

module signed_integer_to_radix_digits_core import r2d_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // value, zero padded
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [SYM_W-1:0]                     m_axis_tdata,  // symbol
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tuser,  // invalid
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [CFG_IDX_W-1:0]                 cfg_addr,
  input  logic [ALPHA_W-1:0]                   cfg_wdata
);

  // configuration registers
  logic [RADIX_W-1:0] radix;
  logic [ALPHA_W-1:0] alphabet_low;
  logic [ALPHA_W-1:0] alphabet_high;
  logic [2*ALPHA_W-1:0] alpha;

  assign alpha = {alphabet_high, alphabet_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      radix         <= RADIX_RESET;
      alphabet_low  <= ALPHA_LOW_RESET;
      alphabet_high <= ALPHA_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RADIX:      radix         <= cfg_wdata[RADIX_W-1:0];
        REG_ALPHA_LOW:  alphabet_low  <= cfg_wdata;
        REG_ALPHA_HIGH: alphabet_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  state_t state;
  state_t state_next;

  logic                  accept;
  logic [VALUE_BITS-1:0] in_value;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  chk_stat_t             chk;
  logic                  chk_start;
  div_stat_t             div;
  logic                  div_start;
  stk_ctrl_t             stk;
  logic [DIGIT_W-1:0]    stk_rdata;
  logic                  stk_empty;

  // output register, the slot is free when empty or being drained
  logic                  out_valid;
  logic [SYM_W-1:0]      out_symbol;
  logic                  out_last;
  logic                  out_invalid;
  logic                  out_free;
  logic                  out_load;
  logic [SYM_W-1:0]      out_symbol_next;
  logic                  out_last_next;
  logic                  out_invalid_next;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_value      = s_axis_tdata[VALUE_BITS-1:0];
  assign out_free      = !out_valid || m_axis_tready;

  // sign and magnitude; the most negative value wraps to its own unsigned magnitude
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= in_value[VALUE_BITS-1];
      mag <= in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    chk_start        = 1'b0;
    div_start        = 1'b0;
    stk.push         = 1'b0;
    stk.pop          = 1'b0;
    out_load         = 1'b0;
    out_symbol_next  = NULL_SYM;
    out_last_next    = 1'b0;
    out_invalid_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          chk_start  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk.done) begin
          if (chk.ok) begin
            div_start  = 1'b1;
            state_next = ST_DIVIDE;
          end else begin
            state_next = ST_INVALID;
          end
        end
      end
      ST_DIVIDE: begin
        // digits come out lsb first and are stacked to reverse them
        if (div.done) begin
          stk.push = 1'b1;
          if (div.last) begin
            state_next = neg ? ST_SIGN : ST_FETCH;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_symbol_next = MINUS_CHAR;
          state_next      = ST_FETCH;
        end
      end
      ST_FETCH: begin
        stk.pop    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_symbol_next = symbol_at(alpha, stk_rdata);
          out_last_next   = stk_empty;
          state_next      = stk_empty ? ST_IDLE : ST_FETCH;
        end
      end
      ST_INVALID: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_last_next    = 1'b1;
          out_invalid_next = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_symbol  <= out_symbol_next;
      out_last    <= out_last_next;
      out_invalid <= out_invalid_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_symbol;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_invalid;

  r2d_check u_check (
    .clk   (clk),
    .rst   (rst),
    .start (chk_start),
    .radix (radix),
    .alpha (alpha),
    .stat  (chk)
  );

  r2d_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .mag_in (mag),
    .radix  (radix),
    .stat   (div)
  );

  r2d_digit_stack #(
    .VALUE_BITS (VALUE_BITS)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (stk),
    .wdata (div.digit),
    .rdata (stk_rdata),
    .empty (stk_empty)
  );

  // an invalid beat is a lone null symbol closing the value
  a_invalid_alone: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == NULL_SYM)))
    else $error("invalid beat malformed");

  // every value drains its digits before the next one is taken
  a_idle_stack_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> stk_empty)
    else $error("digits left over at idle");

endmodule

### rtl/r2d_check.sv
`timescale 1ns / 1ps

module r2d_check import r2d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RADIX_W-1:0]   radix,
  input  logic [2*ALPHA_W-1:0] alpha,
  output chk_stat_t            stat
);

  logic               busy;
  logic [DIGIT_W-1:0] idx;
  logic [SYM_W-1:0]   cur;
  logic               dup;
  logic               range_bad;
  logic               sym_bad;
  logic               bad;
  logic               at_end;

  // one symbol per cycle, compared against every later symbol in use
  always_comb begin
    cur = symbol_at(alpha, idx);
    dup = 1'b0;
    for (int j = 0; j < NUM_SYMS; j++) begin
      if ((RADIX_W'(j) > {1'b0, idx}) && (RADIX_W'(j) < radix) &&
          (symbol_at(alpha, DIGIT_W'(j)) == cur)) begin
        dup = 1'b1;
      end
    end
    range_bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_RADIX));
    sym_bad   = (cur < PRINT_MIN) || (cur > PRINT_MAX) ||
                (cur == PLUS_CHAR) || (cur == MINUS_CHAR);
    bad       = range_bad || sym_bad || dup;
    at_end    = ({1'b0, idx} == (radix - RADIX_W'(1)));
    stat.done = busy && (bad || at_end);
    stat.ok   = !bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (stat.done) begin
      busy <= 1'b0;
    end else if (busy) begin
      idx <= idx + DIGIT_W'(1);
    end
  end

endmodule

### rtl/r2d_divider.sv
`timescale 1ns / 1ps

module r2d_divider import r2d_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] mag_in,
  input  logic [RADIX_W-1:0]    radix,
  output div_stat_t             stat
);

  localparam int unsigned BW = $clog2(VALUE_BITS);

  logic                  busy;
  logic [VALUE_BITS-1:0] mag;
  logic [DIGIT_W-1:0]    rem;
  logic [BW-1:0]         bitcnt;
  logic                  nz;

  logic [RADIX_W-1:0]    trial;
  logic [RADIX_W-1:0]    diff;
  logic                  qbit;
  logic [DIGIT_W-1:0]    rem_next;
  logic [VALUE_BITS-1:0] mag_next;
  logic                  pass_end;
  logic                  nz_next;

  // restoring division, one quotient bit per cycle, msb first
  always_comb begin
    trial    = {rem, mag[VALUE_BITS-1]};
    diff     = trial - radix;
    qbit     = (trial >= radix);
    rem_next = qbit ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    mag_next = {mag[VALUE_BITS-2:0], qbit};
    nz_next  = nz || qbit;
    pass_end = busy && (bitcnt == BW'(VALUE_BITS - 1));

    stat.done  = pass_end;
    stat.last  = !nz_next;
    stat.digit = rem_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (pass_end && !nz_next) begin
      busy <= 1'b0;
    end
  end

  // quotient shifts back into mag; a nonzero quotient starts the next pass
  always_ff @(posedge clk) begin
    if (start) begin
      mag    <= mag_in;
      rem    <= '0;
      bitcnt <= '0;
      nz     <= 1'b0;
    end else if (busy) begin
      mag <= mag_next;
      if (pass_end) begin
        rem    <= '0;
        bitcnt <= '0;
        nz     <= 1'b0;
      end else begin
        rem    <= rem_next;
        bitcnt <= bitcnt + BW'(1);
        nz     <= nz_next;
      end
    end
  end

  a_digit_below_radix: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> ({1'b0, stat.digit} < radix))
    else $error("digit not below radix");

endmodule

### rtl/r2d_digit_stack.sv
`timescale 1ns / 1ps

module r2d_digit_stack import r2d_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  stk_ctrl_t          ctrl,
  input  logic [DIGIT_W-1:0] wdata,
  output logic [DIGIT_W-1:0] rdata,
  output logic               empty
);

  localparam int unsigned AW = $clog2(VALUE_BITS);
  localparam int unsigned CW = $clog2(VALUE_BITS + 1);

  logic [DIGIT_W-1:0] mem [0:VALUE_BITS-1];
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_dec;

  assign count_dec = count - CW'(1);
  assign empty     = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + CW'(1);
    end else if (ctrl.pop) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[count[AW-1:0]] <= wdata;
    end
    if (ctrl.pop) begin
      rdata <= mem[count_dec[AW-1:0]];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> (count < CW'(VALUE_BITS)))
    else $error("digit stack overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> (!empty && !ctrl.push))
    else $error("digit stack underflow");

endmodule

### tb/sv/tb_signed_integer_to_radix_digits_core.sv
`timescale 1ns / 1ps

// one character as it leaves the converter
typedef struct packed {
  logic [r2d_pkg::SYM_W-1:0] symbol;
  logic                      last;
  logic                      invalid;
} char_beat_t;

// keeps its own copy of the three registers, turns each accepted value
// into the characters it must produce and checks the output beats in order
class radix_digit_predictor;
  logic [r2d_pkg::RADIX_W-1:0] radix_reg;
  logic [r2d_pkg::ALPHA_W-1:0] alpha_lo;
  logic [r2d_pkg::ALPHA_W-1:0] alpha_hi;
  char_beat_t                  pending_chars[$];
  int unsigned                 errors;

  function new();
    radix_reg = r2d_pkg::RADIX_RESET;
    alpha_lo  = r2d_pkg::ALPHA_LOW_RESET;
    alpha_hi  = r2d_pkg::ALPHA_HIGH_RESET;
    errors    = 0;
  endfunction

  function void set_register(logic [r2d_pkg::CFG_IDX_W-1:0] idx,
                             logic [r2d_pkg::ALPHA_W-1:0] data);
    case (idx)
      r2d_pkg::REG_RADIX:      radix_reg = data[r2d_pkg::RADIX_W-1:0];
      r2d_pkg::REG_ALPHA_LOW:  alpha_lo  = data;
      r2d_pkg::REG_ALPHA_HIGH: alpha_hi  = data;
      default: ;
    endcase
  endfunction

  function logic [7:0] sym_of(int unsigned idx);
    logic [63:0] word;
    word = (idx < 8) ? alpha_lo : alpha_hi;
    return word[(idx % 8) * 8 +: 8];
  endfunction

  // radix in range and every symbol in use printable, not a sign, and unique
  function bit alphabet_usable();
    logic [7:0] c;
    if (radix_reg < 2 || radix_reg > r2d_pkg::MAX_RADIX) return 1'b0;
    for (int i = 0; i < radix_reg; i++) begin
      c = sym_of(i);
      if (c < r2d_pkg::PRINT_MIN || c > r2d_pkg::PRINT_MAX ||
          c == r2d_pkg::PLUS_CHAR || c == r2d_pkg::MINUS_CHAR) return 1'b0;
      for (int j = i + 1; j < radix_reg; j++)
        if (sym_of(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void take_value(logic [31:0] value);
    logic [32:0] mag;
    int unsigned base;
    int unsigned digit_q[$];
    if (!alphabet_usable()) begin
      pending_chars.push_back('{symbol: r2d_pkg::NULL_SYM, last: 1'b1, invalid: 1'b1});
      return;
    end
    base = radix_reg;
    // 33-bit magnitude so the most negative value stays exact
    mag = {1'b0, value};
    if (value[31]) mag = 33'h1_0000_0000 - mag;
    do begin
      digit_q.push_front(32'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (value[31])
      pending_chars.push_back('{symbol: r2d_pkg::MINUS_CHAR, last: 1'b0, invalid: 1'b0});
    foreach (digit_q[i])
      pending_chars.push_back('{symbol: sym_of(digit_q[i]),
                                last: (i == digit_q.size() - 1), invalid: 1'b0});
  endfunction

  function void flag(string what, logic [7:0] want, logic [7:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
  endfunction

  function void check_char(logic [7:0] sym, logic last, logic inv);
    char_beat_t want;
    if (pending_chars.size() == 0) begin
      flag("unexpected beat (symbol)", 8'hxx, sym);
      return;
    end
    want = pending_chars.pop_front();
    if (want.symbol !== sym)   flag("symbol", want.symbol, sym);
    if (want.last !== last)    flag("last", {7'd0, want.last}, {7'd0, last});
    if (want.invalid !== inv)  flag("invalid", {7'd0, want.invalid}, {7'd0, inv});
  endfunction
endclass

module tb_signed_integer_to_radix_digits_core;
  import r2d_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 220;
  // above the worst case for one value, with margin
  localparam int unsigned DRAIN_CYCLES = 1200;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;   // value
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [SYM_W-1:0]     m_axis_tdata;   // symbol
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;   // invalid
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [ALPHA_W-1:0]   cfg_wdata;

  // no idling on either side while set
  logic quiet = 1'b0;
  int unsigned random_count = 0;

  radix_digit_predictor board = new();

  signed_integer_to_radix_digits_core #(.VALUE_BITS(32)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // output side backpressure, changed on the falling edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 14);
    end
  end

  // every accepted character goes to the checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_char(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // called and returns on a falling edge; tvalid stays up between
  // back-to-back values so it only gets one assignment per edge
  task automatic send_value(logic [31:0] v);
    while (!quiet && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    board.take_value(v);
    @(negedge clk);
  endtask

  // waits for the block to drain, then rewrites all three registers
  task automatic apply_setting(logic [63:0] radix_word, logic [63:0] lo, logic [63:0] hi);
    s_axis_tvalid <= 1'b0;
    while (board.pending_chars.size() != 0 || !s_axis_tready) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_RADIX;
    cfg_wdata <= radix_word;
    @(negedge clk);
    cfg_addr  <= REG_ALPHA_LOW;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_addr  <= REG_ALPHA_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_register(REG_RADIX, radix_word);
    board.set_register(REG_ALPHA_LOW, lo);
    board.set_register(REG_ALPHA_HIGH, hi);
  endtask

  // random alphabet; when broken, one way of making it unusable is picked
  task automatic pick_setting(input bit broken, output logic [63:0] radix_word,
                              output logic [63:0] lo, output logic [63:0] hi);
    logic [7:0]  syms [16];
    bit          used [256];
    int unsigned r;
    int unsigned pos;
    int unsigned other;
    logic [7:0]  c;
    case ($urandom_range(0, 9))
      0, 1, 2: r = 2;
      3, 4:    r = 16;
      default: r = $urandom_range(3, 15);
    endcase
    foreach (used[i]) used[i] = 1'b0;
    foreach (syms[i]) syms[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < r; i++) begin
      do c = 8'($urandom_range(32, 126));
      while (c == PLUS_CHAR || c == MINUS_CHAR || used[c]);
      used[c] = 1'b1;
      syms[i] = c;
    end
    pos = $urandom_range(0, r - 1);
    if (broken) begin
      case ($urandom_range(0, 4))
        0: case ($urandom_range(0, 2))
             0:       r = 0;
             1:       r = 1;
             default: r = $urandom_range(17, 31);
           endcase
        1: syms[pos] = 8'($urandom_range(0, 31));
        2: syms[pos] = 8'($urandom_range(127, 255));
        3: syms[pos] = $urandom_range(0, 1) ? PLUS_CHAR : MINUS_CHAR;
        default: begin
          do other = $urandom_range(0, r - 1); while (other == pos);
          syms[pos] = syms[other];
        end
      endcase
    end
    for (int i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = syms[i];
      hi[i*8 +: 8] = syms[i+8];
    end
    // upper bits of a radix write are junk the register must drop
    radix_word = {$urandom, $urandom};
    radix_word[RADIX_W-1:0] = RADIX_W'(r);
  endtask

  // values aimed at digit count boundaries as well as plain random ones
  function automatic logic [31:0] rand_value(int unsigned base);
    longint p;
    int     x;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6: begin
        x = int'($urandom_range(0, 40)) - 20;
        return x;
      end
      7: case ($urandom_range(0, 4))
           0:       return 32'h8000_0000;
           1:       return 32'h7FFF_FFFF;
           2:       return 32'hFFFF_FFFF;
           3:       return 32'h0000_0000;
           default: return 32'h8000_0001;
         endcase
      default: begin
        p = 1;
        repeat ($urandom_range(1, 31))
          if (p * base <= 64'h7FFF_FFFF) p = p * base;
        p = p + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) p = -p;
        return p[31:0];
      end
    endcase
  endfunction

  initial begin
    logic [63:0] radix_word;
    logic [63:0] lo;
    logic [63:0] hi;
    bit          broken;
    int unsigned n;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_RADIX;
    cfg_wdata     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // decimal alphabet straight out of reset
    send_value(32'h0000_0000);
    send_value(32'h0000_0001);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);

    // hex, full sixteen symbols
    apply_setting(64'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);

    // binary with junk in the unused slots, most negative gives 33 beats
    apply_setting(64'd2, 64'hFF2D_2B00_7F1F_3130, 64'h2B2D_0000_FFFF_2D2B);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0000);

    // radix 3 using the printable edges space and tilde
    apply_setting(64'd3, 64'h2D2D_2D2D_2D78_7E20, 64'h0);
    send_value(32'hFFFF_FFF9);
    send_value(32'h0000_0000);

    // radix out of range, low and high
    apply_setting(64'd0, ALPHA_LOW_RESET, ALPHA_HIGH_RESET);
    send_value(32'h0000_0005);
    apply_setting(64'd1, ALPHA_LOW_RESET, ALPHA_HIGH_RESET);
    send_value(32'hFFFF_FFFF);
    apply_setting(64'd17, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value(32'h0000_0011);
    apply_setting(64'd31, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value(32'h8000_0000);

    // bad symbols: control char, above tilde, plus, minus, duplicate
    apply_setting(64'd10, 64'h3736_1F34_3332_3130, ALPHA_HIGH_RESET);
    send_value(32'h0000_0007);
    apply_setting(64'd10, ALPHA_LOW_RESET, 64'h0000_0000_0000_7F38);
    send_value(32'h0000_0007);
    apply_setting(64'd10, 64'h3736_3534_3332_312B, ALPHA_HIGH_RESET);
    send_value(32'hFFFF_FFF0);
    apply_setting(64'd10, 64'h2D36_3534_3332_3130, ALPHA_HIGH_RESET);
    send_value(32'h0000_0000);
    apply_setting(64'd16, 64'h3736_3534_3332_3130, 64'h4645_4433_4241_3938);
    send_value(32'h1234_5678);

    // random phases, mostly usable alphabets
    while (random_count < RANDOM_ITEMS) begin
      broken = ($urandom_range(0, 99) < 15);
      pick_setting(broken, radix_word, lo, hi);
      apply_setting(radix_word, lo, hi);
      quiet <= (random_count >= 100 && random_count < 160);
      n = broken ? $urandom_range(2, 4) : $urandom_range(6, 20);
      repeat (n) begin
        send_value(rand_value(32'(radix_word[RADIX_W-1:0])));
        random_count++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (board.pending_chars.size() != 0) @(negedge clk);
    // anything extra the block still sends gets flagged by the checker
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
rtl/r2d_pkg.sv
rtl/r2d_check.sv
rtl/r2d_divider.sv
rtl/r2d_digit_stack.sv
rtl/signed_integer_to_radix_digits_core.sv
tb/sv/tb_signed_integer_to_radix_digits_core.sv
